// ----- sv/amrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix core package
// Item record, stage map and per-stage arithmetic of the compass pipeline.
// ----------------------------------------------------------------------------
package amrm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 14;
  localparam int ONE_Q     = 1 << FRAC_BITS;

  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 17;

  localparam int S_HDIFF = 1;
  localparam int S_HSQ   = 2;
  localparam int S_HSUM  = 3;
  localparam int S_SQ0   = 4;
  localparam int S_DS1   = S_SQ0 + SQ_STEPS;
  localparam int S_DV1   = S_DS1 + 1;
  localparam int S_QN    = S_DV1 + DV_STEPS;
  localparam int S_MPROD = S_QN + 1;
  localparam int S_MRND  = S_MPROD + 1;
  localparam int S_DPROD = S_MRND + 1;
  localparam int S_DSUM  = S_DPROD + 1;
  localparam int S_DS2   = S_DSUM + 1;
  localparam int S_DV2   = S_DS2 + 1;
  localparam int S_FIN   = S_DV2 + DV_STEPS;
  localparam int NUM_ST  = S_FIN + 1;

  typedef struct packed {
    logic [2:0][15:0] a;
    logic [2:0][15:0] e;
    logic [5:0][31:0] p;
    logic [2:0][31:0] asq;
    logic [2:0][31:0] esq;
    logic [2:0][31:0] hmag;
    logic [2:0]       hneg;
    logic [2:0][63:0] hsq;
    logic [2:0][63:0] sqx;
    logic [2:0][63:0] sqr;
    logic             degen;
    logic [7:0][47:0] dnum;
    logic [7:0][31:0] dden;
    logic [7:0][16:0] dq;
    logic [7:0]       dneg;
    logic [2:0][15:0] hn;
    logic [2:0][15:0] an;
    logic [2:0][15:0] m;
    logic [1:0][33:0] dot;
    logic [1:0][15:0] incl;
  } amrm_item_t;

  function automatic logic [15:0] qsat(input logic [16:0] q, input logic neg);
    logic [15:0] v;
    v = (q > 17'(ONE_Q)) ? 16'(ONE_Q) : q[15:0];
    return neg ? 16'(-v) : v;
  endfunction

  function automatic amrm_item_t div_step(input amrm_item_t x, input int lo,
                                          input int hi, input int k);
    amrm_item_t y;
    logic [47:0] t;
    y = x;
    for (int j = 0; j < 8; j++) begin
      if (j >= lo && j <= hi) begin
        t = 48'(x.dden[j]) << k;
        if (x.dnum[j] >= t) begin
          y.dnum[j]  = x.dnum[j] - t;
          y.dq[j][k] = 1'b1;
        end
      end
    end
    return y;
  endfunction

  function automatic amrm_item_t amrm_stage(input int s, input amrm_item_t x,
                                            input logic [31:0] min_norm);
    amrm_item_t y;
    logic signed [32:0] d;
    logic signed [33:0] ds;
    logic [32:0] dm;
    logic [33:0] dmw;
    logic signed [16:0] sa;
    logic [16:0] am;
    logic [63:0] bitv;
    logic [31:0] nh;
    logic [31:0] na;
    logic [31:0] ne;
    y = x;
    if (s == S_HDIFF) begin
      for (int j = 0; j < 3; j++) begin
        d = 33'($signed(x.p[2*j])) - 33'($signed(x.p[2*j+1]));
        y.hneg[j] = d[32];
        dm = d[32] ? 33'(-d) : 33'(d);
        y.hmag[j] = dm[31:0];
      end
      y.sqx[1] = 64'(x.asq[0]) + 64'(x.asq[1]) + 64'(x.asq[2]);
      y.sqx[2] = 64'(x.esq[0]) + 64'(x.esq[1]) + 64'(x.esq[2]);
    end else if (s == S_HSQ) begin
      for (int j = 0; j < 3; j++) begin
        y.hsq[j] = 64'(x.hmag[j]) * 64'(x.hmag[j]);
      end
    end else if (s == S_HSUM) begin
      y.sqx[0] = x.hsq[0] + x.hsq[1] + x.hsq[2];
      y.sqr    = '0;
    end else if (s >= S_SQ0 && s < S_DS1) begin
      bitv = 64'(1) << (62 - 2 * (s - S_SQ0));
      for (int j = 0; j < 3; j++) begin
        if (x.sqx[j] >= x.sqr[j] + bitv) begin
          y.sqx[j] = x.sqx[j] - (x.sqr[j] + bitv);
          y.sqr[j] = (x.sqr[j] >> 1) + bitv;
        end else begin
          y.sqr[j] = x.sqr[j] >> 1;
        end
      end
    end else if (s == S_DS1) begin
      nh = x.sqr[0][31:0];
      na = x.sqr[1][31:0];
      y.degen = (nh == '0) || (nh < min_norm);
      y.dq = '0;
      for (int j = 0; j < 3; j++) begin
        y.dnum[j] = (48'(x.hmag[j]) << FRAC_BITS) + 48'(nh >> 1);
        y.dden[j] = nh;
        y.dneg[j] = x.hneg[j];
        sa = 17'($signed(x.a[j]));
        am = sa[16] ? 17'(-sa) : 17'(sa);
        y.dnum[3+j] = (48'(am) << FRAC_BITS) + 48'(na >> 1);
        y.dden[3+j] = na;
        y.dneg[3+j] = sa[16];
      end
    end else if (s >= S_DV1 && s < S_QN) begin
      y = div_step(x, 0, 5, DV_STEPS - 1 - (s - S_DV1));
    end else if (s == S_QN) begin
      for (int j = 0; j < 3; j++) begin
        y.hn[j] = qsat(x.dq[j], x.dneg[j]);
        y.an[j] = qsat(x.dq[3+j], x.dneg[3+j]);
      end
    end else if (s == S_MPROD) begin
      y.p[0] = 32'($signed(x.an[1]) * $signed(x.hn[2]));
      y.p[1] = 32'($signed(x.an[2]) * $signed(x.hn[1]));
      y.p[2] = 32'($signed(x.an[2]) * $signed(x.hn[0]));
      y.p[3] = 32'($signed(x.an[0]) * $signed(x.hn[2]));
      y.p[4] = 32'($signed(x.an[0]) * $signed(x.hn[1]));
      y.p[5] = 32'($signed(x.an[1]) * $signed(x.hn[0]));
    end else if (s == S_MRND) begin
      for (int j = 0; j < 3; j++) begin
        d = 33'($signed(x.p[2*j])) - 33'($signed(x.p[2*j+1]));
        dm = d[32] ? 33'(-d) : 33'(d);
        dm = (dm + 33'(ONE_Q / 2)) >> FRAC_BITS;
        y.m[j] = qsat(dm[16:0], d[32]);
      end
    end else if (s == S_DPROD) begin
      for (int j = 0; j < 3; j++) begin
        y.p[j]   = 32'($signed(x.e[j]) * $signed(x.m[j]));
        y.p[3+j] = 32'($signed(x.e[j]) * $signed(x.an[j]));
      end
    end else if (s == S_DSUM) begin
      for (int i = 0; i < 2; i++) begin
        ds = 34'($signed(x.p[3*i])) + 34'($signed(x.p[3*i+1]))
           + 34'($signed(x.p[3*i+2]));
        y.dot[i] = ds;
      end
    end else if (s == S_DS2) begin
      ne = x.sqr[2][31:0];
      for (int i = 0; i < 2; i++) begin
        dmw = x.dot[i][33] ? 34'(-x.dot[i]) : x.dot[i];
        y.dnum[6+i] = 48'(dmw) + 48'(ne >> 1);
        y.dden[6+i] = ne;
        y.dneg[6+i] = x.dot[i][33];
        y.dq[6+i]   = '0;
      end
    end else if (s >= S_DV2 && s < S_FIN) begin
      y = div_step(x, 6, 7, DV_STEPS - 1 - (s - S_DV2));
    end else if (s == S_FIN) begin
      for (int i = 0; i < 2; i++) begin
        y.incl[i] = qsat(x.dq[6+i], x.dneg[6+i]);
      end
      if (x.degen) begin
        y.hn   = '0;
        y.an   = '0;
        y.m    = '0;
        y.incl = '0;
      end
    end
    return y;
  endfunction

endpackage

// ----- sv/accel_mag_rotation_matrix_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt-compensated compass rotation matrix
// Turns one accelerometer and one magnetometer sample into east, north and
// up rows in Q1.14 plus the magnetic inclination cosine and sine.
// ----------------------------------------------------------------------------
// The core takes one sample pair per clock cycle while the output is not
// stalled, and passes it through a 32-step square-root pipeline and two
// 17-step restoring divider pipelines. A stalled output freezes the
// whole pipeline, so the input is taken only while the pipeline can advance.
// The minimum cross length register must be written while no transaction is
// in flight.
module accel_mag_rotation_matrix_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
  input  logic [95:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // east_x, east_y, east_z, north_x, north_y, north_z,
  // up_x, up_y, up_z, incl_cos, incl_sin
  output logic [175:0] m_axis_tdata_o,
  // status
  output logic         m_axis_tuser_o
);
  import amrm_pkg::*;

  localparam int LAST = NUM_ST - 1;

  logic [31:0]  min_norm_q;
  logic         adv;
  amrm_item_t   in_d;
  amrm_item_t   it_q [NUM_ST];
  amrm_item_t   it_d [NUM_ST];
  logic [NUM_ST-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_norm_q <= 32'd1;
    end else if (cfg_we_i) begin
      min_norm_q <= cfg_wdata_i;
    end
  end

  assign adv = !(v_q[LAST] && !m_axis_tready_i);
  assign s_axis_tready_o = adv;

  always_comb begin
    in_d = '0;
    for (int j = 0; j < 3; j++) begin
      in_d.a[j] = s_axis_tdata_i[SAMPLE_W*j +: SAMPLE_W];
      in_d.e[j] = s_axis_tdata_i[3*SAMPLE_W + SAMPLE_W*j +: SAMPLE_W];
    end
    in_d.p[0] = 32'($signed(in_d.e[1]) * $signed(in_d.a[2]));
    in_d.p[1] = 32'($signed(in_d.e[2]) * $signed(in_d.a[1]));
    in_d.p[2] = 32'($signed(in_d.e[2]) * $signed(in_d.a[0]));
    in_d.p[3] = 32'($signed(in_d.e[0]) * $signed(in_d.a[2]));
    in_d.p[4] = 32'($signed(in_d.e[0]) * $signed(in_d.a[1]));
    in_d.p[5] = 32'($signed(in_d.e[1]) * $signed(in_d.a[0]));
    for (int j = 0; j < 3; j++) begin
      in_d.asq[j] = 32'($signed(in_d.a[j]) * $signed(in_d.a[j]));
      in_d.esq[j] = 32'($signed(in_d.e[j]) * $signed(in_d.e[j]));
    end
  end

  assign it_d[0] = in_d;

  for (genvar g = 1; g < NUM_ST; g++) begin : g_stage
    always_comb begin
      it_d[g] = amrm_stage(g, it_q[g-1], min_norm_q);
    end
  end

  for (genvar g = 0; g < NUM_ST; g++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (adv) begin
        it_q[g] <= it_d[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NUM_ST-2:0], s_axis_tvalid_i};
    end
  end

  assign m_axis_tvalid_o = v_q[LAST];
  assign m_axis_tuser_o  = it_q[LAST].degen;
  assign m_axis_tdata_o  = {it_q[LAST].incl, it_q[LAST].an, it_q[LAST].m, it_q[LAST].hn};

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("degenerate result carries nonzero data");

  a_east_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (($signed(m_axis_tdata_o[15:0]) <= 16'sd16384) &&
       ($signed(m_axis_tdata_o[15:0]) >= -16'sd16384)))
    else $error("east x outside Q1.14 range");

  a_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v_q[0])
    else $error("accepted transaction lost at pipeline entry");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipeline valid bits moved during a stall");

endmodule

// ----- tb/tb_accel_mag_rotation_matrix_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix core testbench
// Drives sensor sample pairs over the input stream with random idling,
// predicts each east, north and up row set and inclination pair in fixed
// point, and compares every output transaction field by field against the predicted result.
// ----------------------------------------------------------------------------
class matrix_scoreboard;
  logic [31:0]  min_norm;
  logic [175:0] exp_data[$];
  logic         exp_stat[$];
  int           errors;

  function new();
    min_norm = 32'd1;
    errors   = 0;
  endfunction

  static function longint unsigned root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  static function longint rdiv(longint num, longint unsigned den);
    longint unsigned q, m;
    longint r;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    if (q > 16384) q = 16384;
    r = q;
    return (num < 0) ? -r : r;
  endfunction

  function void note_sample(logic [95:0] d);
    longint a[3], e[3], h[3], hn[3], an[3], m[3], res[11], dm, da;
    longint unsigned nh, na, ne;
    logic [175:0] packed_res;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(d[16*i +: 16]);
      e[i] = $signed(d[16*(i+3) +: 16]);
    end
    h[0] = e[1] * a[2] - e[2] * a[1];
    h[1] = e[2] * a[0] - e[0] * a[2];
    h[2] = e[0] * a[1] - e[1] * a[0];
    nh = root(h[0] * h[0] + h[1] * h[1] + h[2] * h[2]);
    if (nh == 0 || nh < min_norm) begin
      exp_stat.push_back(1'b1);
      exp_data.push_back('0);
      return;
    end
    na = root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    ne = root(e[0] * e[0] + e[1] * e[1] + e[2] * e[2]);
    for (int i = 0; i < 3; i++) begin
      hn[i] = rdiv(h[i] * 16384, nh);
      an[i] = rdiv(a[i] * 16384, na);
    end
    m[0] = rdiv(an[1] * hn[2] - an[2] * hn[1], 16384);
    m[1] = rdiv(an[2] * hn[0] - an[0] * hn[2], 16384);
    m[2] = rdiv(an[0] * hn[1] - an[1] * hn[0], 16384);
    dm = e[0] * m[0] + e[1] * m[1] + e[2] * m[2];
    da = e[0] * an[0] + e[1] * an[1] + e[2] * an[2];
    for (int i = 0; i < 3; i++) begin
      res[i] = hn[i];
      res[3+i] = m[i];
      res[6+i] = an[i];
    end
    res[9]  = rdiv(dm, ne);
    res[10] = rdiv(da, ne);
    for (int i = 0; i < 11; i++) packed_res[16*i +: 16] = res[i][15:0];
    exp_stat.push_back(1'b0);
    exp_data.push_back(packed_res);
  endfunction

  function void check_result(logic [175:0] d, logic st);
    logic [175:0] ed;
    logic es;
    if (exp_data.size() == 0) begin
      $display("%0t: unexpected result data=%h status=%b", $realtime, d, st);
      errors++;
      return;
    end
    ed = exp_data.pop_front();
    es = exp_stat.pop_front();
    if (es !== st) begin
      $display("%0t: status expected %b actual %b", $realtime, es, st);
      errors++;
    end
    for (int i = 0; i < 11; i++)
      if (ed[16*i +: 16] !== d[16*i +: 16]) begin
        $display("%0t: field %0d expected %0d actual %0d", $realtime, i,
                 $signed(ed[16*i +: 16]), $signed(d[16*i +: 16]));
        errors++;
      end
  endfunction
endclass

module tb_accel_mag_rotation_matrix_core;
  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [31:0]  cfg_wdata_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [95:0]  s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [175:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;

  matrix_scoreboard sb;
  bit quiet_phase;
  bit recv_on;

  accel_mag_rotation_matrix_core DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("** accel_mag_rotation_matrix_core: FAILED **");
    $finish;
  end

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 20)) - 10);
      4: return 16'($signed($urandom_range(0, 600)) - 300);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [95:0] random_pair();
    logic [95:0] d;
    for (int i = 0; i < 6; i++) d[16*i +: 16] = pick_axis();
    if ($urandom_range(0, 19) == 0) d[95:48] = d[47:0];
    if ($urandom_range(0, 29) == 0) d[47:0] = '0;
    return d;
  endfunction

  task automatic send_pair(logic [95:0] d);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_sample(d);
  endtask

  task automatic finish_send();
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.exp_data.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.min_norm = v;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (!recv_on || quiet_phase) begin
        m_axis_tready_i <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] limits[4];
    sb = new();
    quiet_phase     = 1'b0;
    recv_on         = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    recv_on = 1'b1;

    send_pair({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_pair({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd100});
    send_pair({16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd0});
    send_pair({16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd100});
    send_pair({16'd0, 16'd100, 16'd0, 16'd0, 16'd0, 16'd100});
    send_pair({16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1});
    send_pair({3{32'h80008000}});
    send_pair({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    send_pair({16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff});
    send_pair({16'h7fff, 16'h7fff, 16'h0000, 16'h8000, 16'h0000, 16'h7fff});
    send_pair({16'hffff, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'hffff});
    send_pair({16'h1234, 16'hedcb, 16'h0fff, 16'h8001, 16'h4000, 16'hc000});
    finish_send();
    drain();

    limits[0] = 32'd0;
    limits[1] = 32'hffffffff;
    limits[2] = 32'd5000;
    limits[3] = 32'd1;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) write_limit(limits[ph]);
      else write_limit($urandom_range(1, 40000000));
      if (ph == 4) quiet_phase = 1'b1;
      for (int n = 0; n < 220; n++) send_pair(random_pair());
      finish_send();
      drain();
    end

    if (sb.errors == 0) begin
      $display("** accel_mag_rotation_matrix_core: PASSED **");
    end else begin
      $display("** accel_mag_rotation_matrix_core: FAILED **");
    end
    $finish;
  end
endmodule

// ----- accel_mag_rotation_matrix_core.f -----
sv/amrm_pkg.sv
sv/accel_mag_rotation_matrix_core.sv
tb/tb_accel_mag_rotation_matrix_core.sv
